@@ rtl/bwtrq_pkg.sv @@
`default_nettype none
package bwtrq_pkg;

  localparam int MAX_LEN      = 65536;
  localparam int MAX_ALPHA    = 15;
  localparam int MIN_INTERVAL = 16;
  localparam int MAX_INTERVAL = 1024;
  localparam int ROW_COUNT    = MAX_LEN / MIN_INTERVAL + 1;

  localparam int CNT_W   = 17;
  localparam int SYM_W   = 4;
  localparam int IV_W    = 11;
  localparam int ALPHA_W = 4;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int ROW_W   = $clog2(ROW_COUNT);
  localparam int ROWV_W  = MAX_ALPHA * CNT_W;
  localparam int CFGI_W  = 2;
  localparam int STAT_W  = 2;
  localparam int DIVC_W  = $clog2(CNT_W);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RANK = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SYM = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd2;

  localparam logic [CFGI_W-1:0] CFG_ALPHABET = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_INTERVAL = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_TEXT_LEN = 2'd2;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quotient;
    logic [IV_W-1:0]  remainder;
  } div_res_t;

endpackage
`default_nettype wire

@@ rtl/bwt_rank_query_engine.sv @@
`default_nettype none
// FM-index rank engine. A load runs the 17-step serial divider to find whether the new
// length closes a checkpoint row; a load past the configured text length is dropped. A rank
// query runs the 17 divide steps, reads the symbol store once per symbol of the partial
// bucket, then adds the checkpoint count, or for symbol zero subtracts all 15 checkpoint
// counts. A query with a bad symbol or position skips the divider and goes straight to the
// output state. One transaction is worked on at a time; a finished result waits in the
// output register without blocking a following load.
module bwt_rank_query_engine (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_opcode,
  input  wire logic [bwtrq_pkg::SYM_W-1:0]  in_symbol,
  input  wire logic [bwtrq_pkg::CNT_W-1:0]  in_position,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [bwtrq_pkg::CNT_W-1:0]  out_rank_count,
  output logic      [bwtrq_pkg::STAT_W-1:0] out_status,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bwtrq_pkg::CFGI_W-1:0] cfg_index,
  input  wire logic [bwtrq_pkg::CNT_W-1:0]  cfg_data
);
  import bwtrq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ALPHA_W-1:0] alpha_r;
  logic [IV_W-1:0]   iv_r;
  logic [CNT_W-1:0]  text_len_r;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [CNT_W-1:0]  run_cnt_r [MAX_ALPHA];
  logic [CNT_W-1:0]  run_cnt_nxt [MAX_ALPHA];
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_rank_r, out_rank_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic              op_r, op_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  start_r, start_nxt;
  logic [CNT_W-1:0]  scan_k_r, scan_k_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STAT_W-1:0] res_st_r, res_st_nxt;
  logic              row_zero_r, row_zero_nxt;
  logic [ALPHA_W-1:0] alpha_i_r, alpha_i_nxt;

  logic [IV_W-1:0]   eff_iv;
  logic [ALPHA_W-1:0] eff_alpha;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  load_cnt_inc;
  logic              in_acc;
  logic              out_free;
  logic              div_start;
  logic [CNT_W-1:0]  div_dividend;
  div_res_t          div_res;

  logic              sym_we, sym_re;
  logic [SYM_W-1:0]  sym_rdata;
  logic              ck_we, ck_re;
  logic [ROWV_W-1:0] ck_wdata, ck_rdata;
  logic [ROW_W-1:0]  ck_raddr;
  logic [ALPHA_W-1:0] fidx;
  logic [CNT_W-1:0]  ck_field;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    if (iv_r < IV_W'(MIN_INTERVAL)) begin
      eff_iv = IV_W'(MIN_INTERVAL);
    end else if (iv_r > IV_W'(MAX_INTERVAL)) begin
      eff_iv = IV_W'(MAX_INTERVAL);
    end else begin
      eff_iv = iv_r;
    end
    eff_alpha    = (alpha_r == '0) ? ALPHA_W'(1) : alpha_r;
    cap          = (text_len_r < CNT_W'(MAX_LEN)) ? text_len_r : CNT_W'(MAX_LEN);
    load_cnt_inc = load_cnt_r + 1'b1;
  end

  always_comb begin
    for (int a = 0; a < MAX_ALPHA; a++) begin
      ck_wdata[a*CNT_W +: CNT_W] = run_cnt_r[a];
    end
    fidx     = (sym_r != '0) ? ALPHA_W'(sym_r - 1'b1) : alpha_i_r;
    ck_field = row_zero_r ? '0 : ck_rdata[fidx*CNT_W +: CNT_W];
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    run_cnt_nxt   = run_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rank_nxt  = out_rank_r;
    out_stat_nxt  = out_stat_r;
    op_nxt        = op_r;
    sym_nxt       = sym_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    scan_k_nxt    = scan_k_r;
    pend_nxt      = 1'b0;
    cnt_nxt       = cnt_r;
    res_st_nxt    = res_st_r;
    row_zero_nxt  = row_zero_r;
    alpha_i_nxt   = alpha_i_r;
    div_start     = 1'b0;
    div_dividend  = in_position;
    sym_we        = 1'b0;
    sym_re        = 1'b0;
    ck_we         = 1'b0;
    ck_re         = 1'b0;
    ck_raddr      = div_res.quotient[ROW_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_opcode;
          sym_nxt = in_symbol;
          pos_nxt = in_position;
          if (in_opcode == OP_LOAD) begin
            if (load_cnt_r < cap) begin
              sym_we       = 1'b1;
              load_cnt_nxt = load_cnt_inc;
              if (in_symbol != '0) begin
                run_cnt_nxt[ALPHA_W'(in_symbol - 1'b1)] =
                  run_cnt_r[ALPHA_W'(in_symbol - 1'b1)] + 1'b1;
              end
              div_start    = 1'b1;
              div_dividend = load_cnt_inc;
              state_nxt    = S_DIV;
            end
          end else if (in_symbol > eff_alpha) begin
            cnt_nxt    = '0;
            res_st_nxt = ST_BAD_SYM;
            state_nxt  = S_OUT;
          end else if (in_position > load_cnt_r) begin
            cnt_nxt    = '0;
            res_st_nxt = ST_BAD_POS;
            state_nxt  = S_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (op_r == OP_LOAD) begin
            // checkpoint row closes when the new length is a multiple of the interval
            ck_we     = (div_res.remainder == '0);
            state_nxt = S_IDLE;
          end else begin
            ck_re        = 1'b1;
            row_zero_nxt = (div_res.quotient == '0);
            start_nxt    = pos_r - CNT_W'(div_res.remainder);
            scan_k_nxt   = pos_r - CNT_W'(div_res.remainder);
            cnt_nxt      = '0;
            res_st_nxt   = ST_OK;
            alpha_i_nxt  = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_k_r < pos_r) begin
          sym_re     = 1'b1;
          pend_nxt   = 1'b1;
          scan_k_nxt = scan_k_r + 1'b1;
        end
        if (pend_r && (sym_rdata == sym_r)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (!(scan_k_r < pos_r) && !pend_r) begin
          if (sym_r == '0) begin
            cnt_nxt = cnt_r + start_r;
          end
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (sym_r != '0) begin
          cnt_nxt   = cnt_r + ck_field;
          state_nxt = S_OUT;
        end else begin
          // symbol zero: bucket start minus every nonzero count in the row
          cnt_nxt     = cnt_r - ck_field;
          alpha_i_nxt = alpha_i_r + 1'b1;
          if (alpha_i_r == ALPHA_W'(MAX_ALPHA - 1)) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rank_nxt  = cnt_r;
          out_stat_nxt  = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alpha_r     <= ALPHA_W'(4);
      iv_r        <= IV_W'(64);
      text_len_r  <= '0;
      load_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      for (int a = 0; a < MAX_ALPHA; a++) begin
        run_cnt_r[a] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      run_cnt_r   <= run_cnt_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ALPHABET: alpha_r    <= cfg_data[ALPHA_W-1:0];
          CFG_INTERVAL: iv_r       <= cfg_data[IV_W-1:0];
          CFG_TEXT_LEN: text_len_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_rank_r <= out_rank_nxt;
    out_stat_r <= out_stat_nxt;
    op_r       <= op_nxt;
    sym_r      <= sym_nxt;
    pos_r      <= pos_nxt;
    start_r    <= start_nxt;
    scan_k_r   <= scan_k_nxt;
    cnt_r      <= cnt_nxt;
    res_st_r   <= res_st_nxt;
    row_zero_r <= row_zero_nxt;
    alpha_i_r  <= alpha_i_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_rank_count = out_rank_r;
  assign out_status     = out_stat_r;

  bwtrq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_iv),
    .res      (div_res)
  );

  bwtrq_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_LEN)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (load_cnt_r[ADDR_W-1:0]),
    .wdata (in_symbol),
    .re    (sym_re),
    .raddr (scan_k_r[ADDR_W-1:0]),
    .rdata (sym_rdata)
  );

  // row zero is never written; it reads as zero through row_zero_r
  bwtrq_ram #(
    .WIDTH (ROWV_W),
    .DEPTH (ROW_COUNT)
  ) u_ckpt_ram (
    .clk   (clk),
    .we    (ck_we),
    .waddr (div_res.quotient[ROW_W-1:0]),
    .wdata (ck_wdata),
    .re    (ck_re),
    .raddr (ck_raddr),
    .rdata (ck_rdata)
  );

endmodule
`default_nettype wire

@@ rtl/bwtrq_ram.sv @@
`default_nettype none
module bwtrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/bwtrq_div.sv @@
`default_nettype none
module bwtrq_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bwtrq_pkg::CNT_W-1:0] dividend,
  input  wire logic [bwtrq_pkg::IV_W-1:0]  divisor,
  output bwtrq_pkg::div_res_t              res
);
  import bwtrq_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVC_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  quo_r, quo_nxt;
  logic [IV_W-1:0]   rem_r, rem_nxt;
  logic [IV_W-1:0]   dsr_r, dsr_nxt;
  logic [IV_W:0]     trial;
  logic              fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[CNT_W-1]};
    fits     = trial >= {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = DIVC_W'(CNT_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[CNT_W-2:0], fits};
      rem_nxt = fits ? IV_W'(trial - {1'b0, dsr_r}) : trial[IV_W-1:0];
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule
`default_nettype wire
